// File: sv/kslt_pkg.sv
`default_nettype none

package kslt_pkg;

  localparam int unsigned CAPACITY = 64;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned ID_W    = 32;
  localparam int unsigned NAME_W  = 64;
  localparam int unsigned GRADE_W = 10;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned ECNT_W  = 7;

  localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FN_DELETE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_UPDATE = 2'd2;
  localparam logic [FUNC_W-1:0] FN_SEARCH = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] ST_MISSING = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [NAME_W-1:0]  name;
    logic [GRADE_W-1:0] grade;
  } entry_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   key;
    entry_t            rec;
  } op_t;

  typedef struct packed {
    logic   hit;
    entry_t found;
  } tok_t;

endpackage

`default_nettype wire

// File: sv/kslt_cell.sv
`default_nettype none

module kslt_cell #(
  parameter int unsigned Idx  = 0,
  parameter int unsigned CntW = 7
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire kslt_pkg::op_t     op_i,
  input  wire logic [CntW-1:0]   count_i,
  input  wire logic              tok_vld_i,
  input  wire kslt_pkg::tok_t    tok_i,
  input  wire kslt_pkg::entry_t  nbr_i,
  output kslt_pkg::entry_t       ent_o,
  output logic                   tok_vld_o,
  output kslt_pkg::tok_t         tok_o
);

  localparam logic [CntW-1:0] MyIdx = CntW'(Idx);

  kslt_pkg::entry_t ent_q, ent_d;
  kslt_pkg::tok_t   tok_q, tok_d;
  logic             tok_vld_q;
  logic             live;
  logic             match;

  always_comb begin
    live  = MyIdx < count_i;
    match = tok_vld_i && live && !tok_i.hit && (op_i.func != kslt_pkg::FN_INSERT) &&
            (ent_q.id == op_i.key);
    ent_d = ent_q;
    tok_d = tok_i;
    if (tok_vld_i) begin
      case (op_i.func)
        kslt_pkg::FN_INSERT: begin
          if (MyIdx == count_i) begin
            ent_d = op_i.rec;
          end
        end
        kslt_pkg::FN_DELETE: begin
          if (match || tok_i.hit) begin
            ent_d = nbr_i;
          end
        end
        kslt_pkg::FN_UPDATE: begin
          if (match) begin
            ent_d = op_i.rec;
          end
        end
        kslt_pkg::FN_SEARCH: begin
          if (match) begin
            tok_d.found = ent_q;
          end
        end
        default: begin
          ent_d = ent_q;
        end
      endcase
      tok_d.hit = tok_i.hit || match;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_vld_q <= 1'b0;
    end else begin
      tok_vld_q <= tok_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    tok_q <= tok_d;
  end

  assign ent_o     = ent_q;
  assign tok_vld_o = tok_vld_q;
  assign tok_o     = tok_q;

endmodule

`default_nettype wire

// File: sv/keyed_sequential_list_table_top.sv
// Ordered record table with linear key search, one record per cell.
// Input channel (in_valid_i/in_ready_o) carries one operation: insert,
// delete by key, update by key or search by key, with the record fields.
// Output channel (out_valid_o/out_ready_i) returns one result per
// operation: status, the found record on a search hit, and entry count.
// Each operation walks a token down the row of CAPACITY cells, one cell
// per cycle; the cells compare, overwrite, capture or shift as it passes.
// One operation is in flight at a time: the input is not ready while its
// token walks the row or its result waits to be registered.
// A new operation is taken as soon as the previous result is registered,
// even while that result still waits for the receiver.
// When the receiver stalls with a result pending, the next finished
// result is held at the end of the row until the output register frees.
// Reset empties the table (entry count zero) and drops any operation in
// flight; cell contents are not cleared, entries past the count are unused.
`default_nettype none

module keyed_sequential_list_table_top #(
  parameter int unsigned CAPACITY = kslt_pkg::CAPACITY
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [kslt_pkg::FUNC_W-1:0]  func_i,
  input  wire logic [kslt_pkg::ID_W-1:0]    key_i,
  input  wire logic [kslt_pkg::ID_W-1:0]    rec_id_i,
  input  wire logic [kslt_pkg::NAME_W-1:0]  rec_name_i,
  input  wire logic [kslt_pkg::GRADE_W-1:0] rec_grade_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [kslt_pkg::STAT_W-1:0]       status_o,
  output logic [kslt_pkg::ID_W-1:0]         found_id_o,
  output logic [kslt_pkg::NAME_W-1:0]       found_name_o,
  output logic [kslt_pkg::GRADE_W-1:0]      found_grade_o,
  output logic [kslt_pkg::ECNT_W-1:0]       entry_count_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_HOLD
  } state_e;

  state_e           state_q;
  kslt_pkg::op_t    op_q;
  logic [CntW-1:0]  count_q;
  logic             start_q;
  kslt_pkg::tok_t   tail_q;
  logic             out_valid_q;
  logic [kslt_pkg::STAT_W-1:0] status_q;
  kslt_pkg::entry_t found_q;

  kslt_pkg::entry_t ent    [CAPACITY];
  kslt_pkg::tok_t   tok    [CAPACITY];
  logic [CAPACITY-1:0] tok_vld;
  logic             accept;
  logic             out_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    kslt_pkg::entry_t nbr;
    kslt_pkg::tok_t   tin;
    logic             vin;

    if (i == CAPACITY - 1) begin : g_last
      assign nbr = ent[i];
    end else begin : g_mid
      assign nbr = ent[i+1];
    end

    if (i == 0) begin : g_head
      assign tin = '0;
      assign vin = start_q;
    end else begin : g_body
      assign tin = tok[i-1];
      assign vin = tok_vld[i-1];
    end

    kslt_cell #(
      .Idx  (i),
      .CntW (CntW)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .op_i      (op_q),
      .count_i   (count_q),
      .tok_vld_i (vin),
      .tok_i     (tin),
      .nbr_i     (nbr),
      .ent_o     (ent[i]),
      .tok_vld_o (tok_vld[i]),
      .tok_o     (tok[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
      op_q        <= '0;
      tail_q      <= '0;
      status_q    <= kslt_pkg::ST_OK;
      found_q     <= '0;
    end else begin
      start_q <= accept;
      if (out_valid_q && out_ready_i && (state_q != S_HOLD)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q    <= '{func: func_i, key: key_i,
                         rec: '{id: rec_id_i, name: rec_name_i, grade: rec_grade_i}};
            state_q <= S_RUN;
          end
        end
        S_RUN: begin
          if (tok_vld[CAPACITY-1]) begin
            tail_q  <= tok[CAPACITY-1];
            state_q <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            found_q     <= '0;
            if (op_q.func == kslt_pkg::FN_INSERT) begin
              if (count_q == CapCnt) begin
                status_q <= kslt_pkg::ST_FULL;
              end else begin
                status_q <= kslt_pkg::ST_OK;
                count_q  <= count_q + CntW'(1);
              end
            end else if (!tail_q.hit) begin
              status_q <= kslt_pkg::ST_MISSING;
            end else begin
              status_q <= kslt_pkg::ST_OK;
              if (op_q.func == kslt_pkg::FN_DELETE) begin
                count_q <= count_q - CntW'(1);
              end
              if (op_q.func == kslt_pkg::FN_SEARCH) begin
                found_q <= tail_q.found;
              end
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign found_id_o    = found_q.id;
  assign found_name_o  = found_q.name;
  assign found_grade_o = found_q.grade;
  assign entry_count_o = kslt_pkg::ECNT_W'(count_q);

`ifndef SYNTHESIS
  a_one_token : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vld))
    else $error("more than one token in the cell row");

  a_count_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapCnt)
    else $error("entry count exceeds capacity");

  a_token_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q |=> tok_vld[0])
    else $error("started operation did not enter the first cell");

  a_idle_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (tok_vld == '0))
    else $error("token in the cell row while idle");
`endif

endmodule

`default_nettype wire
